### sv/gto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gto_pkg
// Shared types and constants for the topological order engine.
// ----------------------------------------------------------------------------
package gto_pkg;

  localparam int IDX_W  = 7;          // node index as carried on the input
  localparam int NODE_W = 6;          // node index as emitted
  localparam int EDGE_W = 2 * IDX_W;  // one stored edge: {src, dst}

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_ADD_NODE = 2'd1,
    MODE_ADD_EDGE = 2'd2,
    MODE_SORT     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  src_node;
    logic [IDX_W-1:0]  dst_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              from_cycle;
    logic              last;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RD,
    S_CNT_EDGE,
    S_CNT_DEG,
    S_PUSH_RD,
    S_PUSH_CHK,
    S_POP,
    S_POP_WAIT,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_EDGE,
    S_SCAN_DEG,
    S_CYC_RD,
    S_CYC
  } sort_state_t;

endpackage

### sv/gto_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gto_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/gto_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gto_sorter
// Kahn sort sequencer: in-degree RAM with an emitted mark per node, ready
// stack RAM, output register.
// ----------------------------------------------------------------------------
module gto_sorter #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(MAX_NODES+1)-1:0]    node_count,
  input  logic [$clog2(MAX_EDGES+1)-1:0]    edge_count,
  input  logic                              overflow,
  output logic                              busy,
  output logic [$clog2(MAX_EDGES)-1:0]      edge_raddr,
  input  logic [gto_pkg::EDGE_W-1:0]        edge_rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gto_pkg::out_item_t                out_item
);

  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int DW  = ECW;
  localparam int DGW = DW + 1;  // in-degree count with the emitted mark on top

  gto_pkg::sort_state_t state_r, state_nxt;

  logic [ECW-1:0]             e_r, e_nxt;
  logic [NCW-1:0]             i_r, i_nxt;
  logic [NCW-1:0]             sp_r, sp_nxt;
  logic [NCW-1:0]             k_r, k_nxt;
  logic [gto_pkg::NODE_W-1:0] cur_r, cur_nxt;
  logic [NAW-1:0]             d_r, d_nxt;

  logic                       out_valid_r;
  gto_pkg::out_item_t         out_item_r;

  logic                       deg_we;
  logic [NAW-1:0]             deg_waddr, deg_raddr;
  logic [DGW-1:0]             deg_wdata, deg_rdata;
  logic                       deg_mark;
  logic [DW-1:0]              deg_cnt;
  logic                       stk_we;
  logic [NAW-1:0]             stk_waddr, stk_raddr;
  logic [gto_pkg::NODE_W-1:0] stk_wdata, stk_rdata;

  logic                       emit;
  logic [gto_pkg::NODE_W-1:0] emit_node;
  logic                       emit_cyc;

  logic [gto_pkg::IDX_W-1:0]  edge_src, edge_dst, n_idx;
  logic                       dst_known, src_hit, slot_free;
  logic [NCW-1:0]             n_dec, sp_dec;

  assign edge_src  = edge_rdata[gto_pkg::EDGE_W-1 -: gto_pkg::IDX_W];
  assign edge_dst  = edge_rdata[gto_pkg::IDX_W-1:0];
  assign n_idx     = gto_pkg::IDX_W'(node_count);
  assign dst_known = edge_dst < n_idx;
  assign src_hit   = edge_src == gto_pkg::IDX_W'(cur_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign n_dec     = node_count - NCW'(1);
  assign sp_dec    = sp_r - NCW'(1);
  assign deg_mark  = deg_rdata[DGW-1];
  assign deg_cnt   = deg_rdata[DW-1:0];

  gto_ram #(.WIDTH(DGW), .DEPTH(MAX_NODES)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gto_ram #(.WIDTH(gto_pkg::NODE_W), .DEPTH(MAX_NODES)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gto_pkg::S_IDLE: begin
        if (start && node_count != '0) state_nxt = gto_pkg::S_CLR;
      end
      gto_pkg::S_CLR: begin
        if (i_r == n_dec) state_nxt = gto_pkg::S_CNT_RD;
      end
      gto_pkg::S_CNT_RD: begin
        state_nxt = (e_r == edge_count) ? gto_pkg::S_PUSH_RD : gto_pkg::S_CNT_EDGE;
      end
      gto_pkg::S_CNT_EDGE: begin
        state_nxt = dst_known ? gto_pkg::S_CNT_DEG : gto_pkg::S_CNT_RD;
      end
      gto_pkg::S_CNT_DEG:  state_nxt = gto_pkg::S_CNT_RD;
      gto_pkg::S_PUSH_RD: begin
        state_nxt = (i_r == node_count) ? gto_pkg::S_POP : gto_pkg::S_PUSH_CHK;
      end
      gto_pkg::S_PUSH_CHK: state_nxt = gto_pkg::S_PUSH_RD;
      gto_pkg::S_POP: begin
        state_nxt = (sp_r == '0) ? gto_pkg::S_CYC_RD : gto_pkg::S_POP_WAIT;
      end
      gto_pkg::S_POP_WAIT: state_nxt = gto_pkg::S_EMIT;
      gto_pkg::S_EMIT: begin
        if (deg_mark)       state_nxt = gto_pkg::S_POP;
        else if (slot_free) state_nxt = gto_pkg::S_SCAN_RD;
      end
      gto_pkg::S_SCAN_RD: begin
        state_nxt = (e_r == edge_count) ? gto_pkg::S_POP : gto_pkg::S_SCAN_EDGE;
      end
      gto_pkg::S_SCAN_EDGE: begin
        state_nxt = (src_hit && dst_known) ? gto_pkg::S_SCAN_DEG : gto_pkg::S_SCAN_RD;
      end
      gto_pkg::S_SCAN_DEG: state_nxt = gto_pkg::S_SCAN_RD;
      gto_pkg::S_CYC_RD: begin
        state_nxt = (i_r == node_count) ? gto_pkg::S_IDLE : gto_pkg::S_CYC;
      end
      gto_pkg::S_CYC: begin
        if (deg_mark || slot_free) state_nxt = gto_pkg::S_CYC_RD;
      end
      default: state_nxt = gto_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and counters
  always_comb begin
    e_nxt      = e_r;
    i_nxt      = i_r;
    sp_nxt     = sp_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    d_nxt      = d_r;
    edge_raddr = e_r[EAW-1:0];
    deg_we     = 1'b0;
    deg_waddr  = i_r[NAW-1:0];
    deg_wdata  = '0;
    deg_raddr  = i_r[NAW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp_r[NAW-1:0];
    stk_wdata  = gto_pkg::NODE_W'(i_r);
    stk_raddr  = sp_dec[NAW-1:0];
    emit       = 1'b0;
    emit_node  = cur_r;
    emit_cyc   = 1'b0;
    unique case (state_r)
      gto_pkg::S_IDLE: begin
        e_nxt  = '0;
        i_nxt  = '0;
        sp_nxt = '0;
        k_nxt  = '0;
      end
      // zero the in-degree table and the emitted marks
      gto_pkg::S_CLR: begin
        deg_we = 1'b1;
        i_nxt  = (i_r == n_dec) ? '0 : i_r + NCW'(1);
      end
      gto_pkg::S_CNT_RD: begin
        i_nxt = '0;
      end
      gto_pkg::S_CNT_EDGE: begin
        deg_raddr = edge_dst[NAW-1:0];
        d_nxt     = edge_dst[NAW-1:0];
        if (!dst_known) e_nxt = e_r + ECW'(1);
      end
      // count one incoming edge
      gto_pkg::S_CNT_DEG: begin
        deg_we    = 1'b1;
        deg_waddr = d_r;
        deg_wdata = {1'b0, deg_cnt + DW'(1)};
        e_nxt     = e_r + ECW'(1);
      end
      gto_pkg::S_PUSH_RD: ;
      // push start nodes in node order
      gto_pkg::S_PUSH_CHK: begin
        if (deg_rdata == '0) begin
          stk_we = 1'b1;
          sp_nxt = sp_r + NCW'(1);
        end
        i_nxt = i_r + NCW'(1);
      end
      gto_pkg::S_POP: begin
        if (sp_r != '0) sp_nxt = sp_dec;
        i_nxt = '0;
      end
      // latch the popped node and fetch its mark
      gto_pkg::S_POP_WAIT: begin
        cur_nxt   = stk_rdata;
        deg_raddr = stk_rdata[NAW-1:0];
      end
      // emit the popped node and mark it
      gto_pkg::S_EMIT: begin
        deg_raddr = cur_r[NAW-1:0];
        e_nxt     = '0;
        if (!deg_mark && slot_free) begin
          emit      = 1'b1;
          k_nxt     = k_r + NCW'(1);
          deg_we    = 1'b1;
          deg_waddr = cur_r[NAW-1:0];
          deg_wdata = {1'b1, deg_cnt};
        end
      end
      gto_pkg::S_SCAN_RD: ;
      gto_pkg::S_SCAN_EDGE: begin
        deg_raddr = edge_dst[NAW-1:0];
        d_nxt     = edge_dst[NAW-1:0];
        if (!(src_hit && dst_known)) e_nxt = e_r + ECW'(1);
      end
      // drop the in-degree, push on reaching zero
      gto_pkg::S_SCAN_DEG: begin
        deg_waddr = d_r;
        deg_wdata = {1'b0, deg_cnt - DW'(1)};
        stk_wdata = gto_pkg::NODE_W'(d_r);
        if (deg_cnt != '0) begin
          deg_we = 1'b1;
          if (deg_cnt == DW'(1)) begin
            stk_we = 1'b1;
            sp_nxt = sp_r + NCW'(1);
          end
        end
        e_nxt = e_r + ECW'(1);
      end
      gto_pkg::S_CYC_RD: ;
      // append the nodes left on or behind a cycle
      gto_pkg::S_CYC: begin
        emit_node = gto_pkg::NODE_W'(i_r);
        emit_cyc  = 1'b1;
        if (deg_mark) begin
          i_nxt = i_r + NCW'(1);
        end else if (slot_free) begin
          emit  = 1'b1;
          k_nxt = k_r + NCW'(1);
          i_nxt = i_r + NCW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gto_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Counters and output payload
  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    i_r   <= i_nxt;
    sp_r  <= sp_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    d_r   <= d_nxt;
    if (emit) begin
      out_item_r.node_index <= emit_node;
      out_item_r.from_cycle <= emit_cyc;
      out_item_r.last       <= k_r == n_dec;
      out_item_r.overflow   <= overflow;
    end
  end

  assign busy      = state_r != gto_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/graph_topological_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_topological_order
// Graph loader and Kahn topological sort with a LIFO ready stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes clear, add-node,
//   add-edge and sort items. Load items never stall and may follow back to
//   back. A sort item on a non-empty graph raises in_stall from the next cycle
//   until the whole order is in the output register and the sequencer is idle.
//   Output channel (out_valid / out_stall / out_item) gives one item per
//   node, in processing order, with last set on the final one. An empty
//   graph gives no item.
//   The sort clears the in-degree table, counts the in-degree of each node
//   over the stored edges, pushes the start nodes, then pops each stack node,
//   emits it and scans every stored edge for its successors; last it walks
//   all nodes and appends those never emitted, flagged from_cycle.
//   A stalled receiver freezes the output register; the sequencer waits at
//   its next emit.
//   Reset clears node count, edge count, overflow flag and the output valid;
//   the edge RAM needs no clearing since only loaded entries are read.
// ----------------------------------------------------------------------------
module graph_topological_order #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gto_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gto_pkg::out_item_t out_item
);

  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);

  logic [NCW-1:0] node_count_r, node_count_nxt;
  logic [ECW-1:0] edge_count_r, edge_count_nxt;
  logic           overflow_r, overflow_nxt;
  logic           accept, busy, start, edge_we;
  logic [EAW-1:0] edge_raddr;
  logic [gto_pkg::EDGE_W-1:0] edge_rdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign start    = accept && in_item.mode == gto_pkg::MODE_SORT;
  assign edge_we  = accept && in_item.mode == gto_pkg::MODE_ADD_EDGE
                    && edge_count_r < ECW'(MAX_EDGES);

  // Decode load items
  always_comb begin
    node_count_nxt = node_count_r;
    edge_count_nxt = edge_count_r;
    overflow_nxt   = overflow_r;
    if (accept) begin
      unique case (in_item.mode)
        gto_pkg::MODE_CLEAR: begin
          node_count_nxt = '0;
          edge_count_nxt = '0;
          overflow_nxt   = 1'b0;
        end
        gto_pkg::MODE_ADD_NODE: begin
          if (node_count_r < NCW'(MAX_NODES)) node_count_nxt = node_count_r + NCW'(1);
          else                                overflow_nxt   = 1'b1;
        end
        gto_pkg::MODE_ADD_EDGE: begin
          if (edge_we) edge_count_nxt = edge_count_r + ECW'(1);
          else         overflow_nxt   = 1'b1;
        end
        gto_pkg::MODE_SORT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      edge_count_r <= '0;
      overflow_r   <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      edge_count_r <= edge_count_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  gto_ram #(.WIDTH(gto_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_count_r[EAW-1:0]),
    .wdata ({in_item.src_node, in_item.dst_node}),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  gto_sorter #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_sorter (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .node_count (node_count_r),
    .edge_count (edge_count_r),
    .overflow   (overflow_r),
    .busy       (busy),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

### sv/gto_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gto_checker
// Port-level checks for the topological order engine.
// ----------------------------------------------------------------------------
module gto_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gto_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input gto_pkg::out_item_t out_item
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // A pending non-final node means the sort is still running
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> in_stall)
    else $error("input open while sort incomplete");

  // After the final node only a new running sort can fill the output
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.last |=> !out_valid || in_stall)
    else $error("item after final node");

  // Load items never stall the next item
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.mode != gto_pkg::MODE_SORT |=> !in_stall)
    else $error("stall after load item");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind graph_topological_order gto_checker u_gto_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
